[hdl/fce_pkg.sv]
// ----------------------------------------------------------------------------
// fce_pkg
// Shared widths, codes and reset values for the feedback comb echo core.
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam int MAX_DELAY_DEFAULT = 4096;

  localparam int SAMPLE_W = 16;
  localparam int LENGTH_W = 13;
  localparam int GAIN_W   = 15;
  localparam int CFG_W    = 15;
  localparam int FRAC_W   = 15;

  localparam logic [LENGTH_W-1:0] DELAY_LENGTH_RESET = 13'd4096;
  localparam logic [GAIN_W-1:0]   DECAY_GAIN_RESET   = 15'd16384;

  // Operation codes carried in s_tuser.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_DELAY_LENGTH = 1'b0;
  localparam logic REG_DECAY_GAIN   = 1'b1;

endpackage

[hdl/feedback_comb_echo_core.sv]
// ----------------------------------------------------------------------------
// feedback_comb_echo_core
// Feedback comb echo on signed 16-bit samples, delay line in one RAM.
// ----------------------------------------------------------------------------
// Filter words are taken one per clock while no clear sweep runs and the
// output is not stalled. The delay line sits in a single RAM with a
// registered read; the read is issued when a word is taken, and the stage
// after it does the multiply, add, round toward zero and saturate, writes
// the result back and loads the output register. A result of the previous
// word to the same entry is forwarded around the RAM. A clear word, and
// reset, start a sweep that writes zero to all MAX_DELAY entries, one per
// cycle, with s_tready low; configuration writes are taken at any time.
module feedback_comb_echo_core
  import fce_pkg::*;
#(
  parameter int MAX_DELAY = MAX_DELAY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // slave side
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic signed [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  input  logic                       s_tuser,   // [0] operation
  // master side
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic signed [SAMPLE_W-1:0] m_tdata,   // [15:0] echoed_sample
  output logic                       m_tuser,   // [0] saturated
  // configuration
  input  logic                       cfg_wen,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CW = (AW + 1 > LENGTH_W) ? AW + 1 : LENGTH_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);
  localparam logic [CW-1:0] MAX_LEN   = CW'(MAX_DELAY);

  logic [LENGTH_W-1:0] delay_length;
  logic [GAIN_W-1:0]   decay_gain;

  logic                clearing;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       pos;
  logic [AW-1:0]       pos_next;
  logic [CW-1:0]       pos_inc;

  logic                       s1_valid;
  logic [AW-1:0]              s1_addr;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       fwd_hit;
  logic signed [SAMPLE_W-1:0] fwd_data;

  logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic signed [SAMPLE_W-1:0] ram_wdata;

  logic s_go, s1_go, s1_fire, filter_acc, clear_acc;

  logic signed [SAMPLE_W-1:0]   entry;
  logic signed [SAMPLE_W-1:0]   gain_s;
  logic signed [31:0]           product;
  logic signed [32:0]           total;
  logic signed [17:0]           q;
  logic signed [SAMPLE_W-1:0]   q_sat;
  logic                         sat;

  // handshake
  assign s1_go      = !m_tvalid || m_tready;
  assign s1_fire    = s1_valid && s1_go;
  assign s_tready   = !clearing && (!s1_valid || s1_go);
  assign s_go       = s_tvalid && s_tready;
  assign filter_acc = s_go && (s_tuser == OP_FILTER);
  assign clear_acc  = s_go && (s_tuser == OP_CLEAR);

  // position advance, wrap at effective length (0 acts as 1, cap at MAX_DELAY)
  always_comb begin
    pos_inc = CW'(pos) + CW'(1);
    if ((pos_inc >= CW'(delay_length)) || (pos_inc == MAX_LEN)) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[AW-1:0];
    end
  end

  // echo arithmetic
  always_comb begin
    entry   = fwd_hit ? fwd_data : rd_data;
    gain_s  = signed'({1'b0, decay_gain});
    product = gain_s * entry;
    total   = signed'({{2{s1_sample[SAMPLE_W-1]}}, s1_sample, {FRAC_W{1'b0}}})
            + signed'({product[31], product});
    // truncate toward zero
    q = total[32:FRAC_W] + 18'(total[32] && (|total[FRAC_W-1:0]));
    if (q > 18'sd32767) begin
      q_sat = 16'sh7fff;
      sat   = 1'b1;
    end else if (q < -18'sd32768) begin
      q_sat = 16'sh8000;
      sat   = 1'b1;
    end else begin
      q_sat = q[SAMPLE_W-1:0];
      sat   = 1'b0;
    end
  end

  // RAM write port: clear sweep or write-back
  always_comb begin
    ram_we    = clearing || s1_fire;
    ram_waddr = clearing ? clr_addr : s1_addr;
    ram_wdata = clearing ? '0 : q_sat;
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_waddr] <= ram_wdata;
    end
    if (filter_acc) begin
      rd_data <= mem[pos];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= DELAY_LENGTH_RESET;
      decay_gain   <= DECAY_GAIN_RESET;
      clearing     <= 1'b1;
      clr_addr     <= '0;
      pos          <= '0;
      s1_valid     <= 1'b0;
      fwd_hit      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_DELAY_LENGTH: delay_length <= cfg_data[LENGTH_W-1:0];
          REG_DECAY_GAIN:   decay_gain   <= cfg_data[GAIN_W-1:0];
          default:          ;
        endcase
      end

      if (clear_acc) begin
        clearing <= 1'b1;
        clr_addr <= '0;
        pos      <= '0;
      end else if (clearing) begin
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + AW'(1);
      end else if (filter_acc) begin
        pos <= pos_next;
      end

      if (filter_acc) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_fire && (s1_addr == pos);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (filter_acc) begin
      s1_addr   <= pos;
      s1_sample <= s_tdata;
      fwd_data  <= q_sat;
    end
    if (s1_fire) begin
      m_tdata <= q_sat;
      m_tuser <= sat;
    end
  end

endmodule
